>>> rtl/pkq_pkg.sv
// Package for the button and pad key qualifier.
// Holds sizes, action and register codes, configuration struct and time helpers.
// No dependencies.
package pkq_pkg;

    localparam int PAD_KEYS     = 7;
    localparam int BUTTONS      = 2;
    localparam int LONG_LEFT_MS = 500;

    localparam int PAD_INPUTS = 7;
    localparam int BTN_INPUTS = 2;
    localparam int LEFT_KEY   = 2;

    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [3:0] {
        ACT_NONE      = 4'd0,
        ACT_RIGHT     = 4'd1,
        ACT_BACK      = 4'd2,
        ACT_CONFIRM   = 4'd3,
        ACT_LONG_LEFT = 4'd4,
        ACT_UP        = 4'd5,
        ACT_DOWN      = 4'd6,
        ACT_LEFT      = 4'd7,
        ACT_HOME      = 4'd8
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BTN_DEBOUNCE = 3'd0,
        CFG_BTN_LONG     = 3'd1,
        CFG_PAD_ENABLE   = 3'd2,
        CFG_PAD_DEBOUNCE = 3'd3,
        CFG_RPT_MASK     = 3'd4,
        CFG_RPT_DELAY    = 3'd5,
        CFG_RPT_PERIOD   = 3'd6,
        CFG_HOLD_CAP     = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESSED = 2'd1,
        PH_LONG    = 2'd2
    } t_btn_phase;

    typedef struct packed {
        logic [MS_W-1:0]       btn_debounce_ms;
        logic [MS_W-1:0]       btn_long_ms;
        logic                  pad_enable;
        logic [MS_W-1:0]       pad_debounce_ms;
        logic [PAD_INPUTS-1:0] rpt_mask;
        logic [MS_W-1:0]       rpt_delay_ms;
        logic [MS_W-1:0]       rpt_period_ms;
        logic [MS_W-1:0]       hold_cap_ms;
    } t_cfg;

    typedef struct packed {
        logic [BUTTONS-1:0]  btn_go;
        logic [PAD_KEYS-1:0] key_go;
        t_action             action;
    } t_grant;

    // signed view of a wrapping difference is at least lim
    function automatic logic elapsed_ge(input logic [TIME_W-1:0] diff,
                                        input logic [TIME_W-1:0] lim);
        return !diff[TIME_W-1] && (diff >= lim);
    endfunction

    function automatic t_action key_action(input int idx);
        t_action a;
        case (idx)
            0:       a = ACT_UP;
            1:       a = ACT_DOWN;
            2:       a = ACT_LEFT;
            3:       a = ACT_RIGHT;
            4:       a = ACT_CONFIRM;
            5:       a = ACT_BACK;
            6:       a = ACT_HOME;
            default: a = ACT_NONE;
        endcase
        return a;
    endfunction

    function automatic t_action btn_short_action(input int idx);
        t_action a;
        case (idx)
            0:       a = ACT_RIGHT;
            1:       a = ACT_CONFIRM;
            default: a = ACT_NONE;
        endcase
        return a;
    endfunction

    function automatic t_action btn_long_action(input int idx);
        t_action a;
        case (idx)
            0:       a = ACT_BACK;
            1:       a = ACT_LONG_LEFT;
            default: a = ACT_NONE;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/pkq_button_lane.sv
// One push-button lane: idle / pressed / long-fired machine with press timestamp.
// Depends on pkq_pkg.
module pkq_button_lane (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_commit,
    input  logic [pkq_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                           i_pressed,
    input  pkq_pkg::t_cfg                  i_cfg,
    input  pkq_pkg::t_action               i_short_act,
    input  pkq_pkg::t_action               i_long_act,
    output pkq_pkg::t_action               o_act
);
    import pkq_pkg::*;

    t_btn_phase        r_phase, n_phase;
    logic [TIME_W-1:0] r_press_time, n_press_time;
    logic [TIME_W-1:0] dur;

    assign dur = i_now_ms - r_press_time;

    always_comb begin
        n_phase      = r_phase;
        n_press_time = r_press_time;
        unique case (r_phase)
            PH_PRESSED: begin
                if (i_pressed) begin
                    if (dur > {{(TIME_W-MS_W){1'b0}}, i_cfg.btn_long_ms}) begin
                        n_phase = PH_LONG;
                    end
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_LONG: begin
                if (!i_pressed) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                if (i_pressed) begin
                    n_phase      = PH_PRESSED;
                    n_press_time = i_now_ms;
                end
            end
        endcase
    end

    always_comb begin
        o_act = ACT_NONE;
        unique case (r_phase)
            PH_PRESSED: begin
                if (i_pressed) begin
                    if (dur > {{(TIME_W-MS_W){1'b0}}, i_cfg.btn_long_ms}) begin
                        o_act = i_long_act;
                    end
                end else if (dur >= {{(TIME_W-MS_W){1'b0}}, i_cfg.btn_debounce_ms}) begin
                    o_act = i_short_act;
                end
            end
            default: o_act = ACT_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_press_time <= '0;
        end else if (i_commit) begin
            r_phase      <= n_phase;
            r_press_time <= n_press_time;
        end
    end

endmodule

>>> rtl/pkq_key_lane.sv
// One pad key lane: stable-time debounce, stuck-key guard, auto repeat, left long press.
// Depends on pkq_pkg.
module pkq_key_lane (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_commit,
    input  logic [pkq_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                           i_raw,
    input  pkq_pkg::t_cfg                  i_cfg,
    input  logic                           i_rpt_en,
    input  logic                           i_is_left,
    input  pkq_pkg::t_action               i_key_act,
    output pkq_pkg::t_action               o_act
);
    import pkq_pkg::*;

    logic              r_last_raw, r_stable, r_seen, r_long_done;
    logic              n_last_raw, n_stable, n_seen, n_long_done;
    logic [TIME_W-1:0] r_change_time, r_press_time, r_repeat_time;
    logic [TIME_W-1:0] n_change_time, n_press_time, n_repeat_time;
    logic              changed, deb_ok, nd;
    logic [TIME_W-1:0] since_change, held, rpt_diff;

    assign changed      = i_raw != r_last_raw;
    assign since_change = i_now_ms - r_change_time;
    assign held         = i_now_ms - r_press_time;
    assign rpt_diff     = i_now_ms - r_repeat_time;
    assign deb_ok = changed ? (i_cfg.pad_debounce_ms == '0)
                            : elapsed_ge(since_change,
                                         {{(TIME_W-MS_W){1'b0}}, i_cfg.pad_debounce_ms});
    assign nd = deb_ok ? i_raw : r_stable;

    always_comb begin
        n_seen        = r_seen | ~i_raw;
        n_last_raw    = i_raw;
        n_change_time = changed ? i_now_ms : r_change_time;
        n_stable      = r_stable;
        n_long_done   = r_long_done;
        n_press_time  = r_press_time;
        n_repeat_time = r_repeat_time;
        o_act         = ACT_NONE;
        if (nd && !r_stable) begin
            n_stable      = 1'b1;
            n_press_time  = i_now_ms;
            n_repeat_time = i_now_ms + {{(TIME_W-MS_W){1'b0}}, i_cfg.rpt_delay_ms};
            n_long_done   = 1'b0;
            if (n_seen) begin
                o_act = i_key_act;
            end
        end else if (i_rpt_en && nd && r_stable && n_seen) begin
            if (i_is_left && !r_long_done
                && elapsed_ge(held, TIME_W'(LONG_LEFT_MS))) begin
                n_long_done = 1'b1;
                o_act       = ACT_LONG_LEFT;
            end else if (!elapsed_ge(held, {{(TIME_W-MS_W){1'b0}}, i_cfg.hold_cap_ms})
                         && !rpt_diff[TIME_W-1]) begin
                n_repeat_time = i_now_ms + {{(TIME_W-MS_W){1'b0}}, i_cfg.rpt_period_ms};
                o_act         = i_key_act;
            end
        end else if (!nd && r_stable) begin
            n_stable    = 1'b0;
            n_long_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b0;
            r_stable      <= 1'b0;
            r_seen        <= 1'b0;
            r_long_done   <= 1'b0;
            r_change_time <= '0;
            r_press_time  <= '0;
            r_repeat_time <= '0;
        end else if (i_commit) begin
            r_last_raw    <= n_last_raw;
            r_stable      <= n_stable;
            r_seen        <= n_seen;
            r_long_done   <= n_long_done;
            r_change_time <= n_change_time;
            r_press_time  <= n_press_time;
            r_repeat_time <= n_repeat_time;
        end
    end

endmodule

>>> rtl/pkq_merge.sv
// Priority merge: first lane with an action wins; lanes after it do not advance.
// Depends on pkq_pkg.
module pkq_merge (
    input  pkq_pkg::t_action i_btn_act [pkq_pkg::BUTTONS],
    input  pkq_pkg::t_action i_key_act [pkq_pkg::PAD_KEYS],
    input  logic             i_pad_active,
    output pkq_pkg::t_grant  o_grant
);
    import pkq_pkg::*;

    logic blocked;

    always_comb begin
        blocked        = 1'b0;
        o_grant.action = ACT_NONE;
        o_grant.btn_go = '0;
        o_grant.key_go = '0;
        for (int i = 0; i < BUTTONS; i++) begin
            o_grant.btn_go[i] = !blocked;
            if (!blocked && i_btn_act[i] != ACT_NONE) begin
                o_grant.action = i_btn_act[i];
                blocked        = 1'b1;
            end
        end
        for (int k = 0; k < PAD_KEYS; k++) begin
            o_grant.key_go[k] = !blocked && i_pad_active;
            if (!blocked && i_pad_active && i_key_act[k] != ACT_NONE) begin
                o_grant.action = i_key_act[k];
                blocked        = 1'b1;
            end
        end
    end

endmodule

>>> rtl/button_and_pad_key_qualifier_unit.sv
// Top level of the button and pad key qualifier: config registers, lanes, merge, output stage.
// Depends on pkq_pkg, pkq_button_lane, pkq_key_lane, pkq_merge.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  poll    | i_in_valid/o_in_ready, i_now_ms, i_button_a/b_  | in
//          | pressed, i_pad_connected, i_pad_keys            |
//  action  | o_out_valid/i_out_ready, o_action               | out
//  config  | i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data| in
//
// One poll per cycle unless the sink stalls; the action shows in the cycle after the accepted poll.
// All lanes evaluate in parallel in that cycle; the priority merge is the longest path.
// The output register holds the action while the sink stalls; a new poll is taken
// in the same cycle the held action leaves. Config is always ready.
// Synchronous reset restores register defaults and clears all lane state.
module button_and_pad_key_qualifier_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [pkq_pkg::TIME_W-1:0]        i_now_ms,
    input  logic                              i_button_a_pressed,
    input  logic                              i_button_b_pressed,
    input  logic                              i_pad_connected,
    input  logic [pkq_pkg::PAD_INPUTS-1:0]    i_pad_keys,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [3:0]                        o_action,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pkq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pkq_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import pkq_pkg::*;

    t_cfg                  r_cfg;
    logic                  r_out_valid;
    t_action               r_action;
    logic                  accept;
    logic                  pad_active;
    logic [BTN_INPUTS-1:0] btn_vec;
    t_action               btn_act [BUTTONS];
    t_action               key_act [PAD_KEYS];
    t_grant                grant;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign pad_active  = r_cfg.pad_enable && i_pad_connected;
    assign btn_vec     = {i_button_b_pressed, i_button_a_pressed};
    assign o_out_valid = r_out_valid;
    assign o_action    = r_action;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.btn_debounce_ms <= MS_W'(30);
            r_cfg.btn_long_ms     <= MS_W'(500);
            r_cfg.pad_enable      <= 1'b1;
            r_cfg.pad_debounce_ms <= MS_W'(30);
            r_cfg.rpt_mask        <= '0;
            r_cfg.rpt_delay_ms    <= MS_W'(450);
            r_cfg.rpt_period_ms   <= MS_W'(110);
            r_cfg.hold_cap_ms     <= MS_W'(1500);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BTN_DEBOUNCE: r_cfg.btn_debounce_ms <= i_cfg_data;
                CFG_BTN_LONG:     r_cfg.btn_long_ms     <= i_cfg_data;
                CFG_PAD_ENABLE:   r_cfg.pad_enable      <= i_cfg_data[0];
                CFG_PAD_DEBOUNCE: r_cfg.pad_debounce_ms <= i_cfg_data;
                CFG_RPT_MASK:     r_cfg.rpt_mask        <= i_cfg_data[PAD_INPUTS-1:0];
                CFG_RPT_DELAY:    r_cfg.rpt_delay_ms    <= i_cfg_data;
                CFG_RPT_PERIOD:   r_cfg.rpt_period_ms   <= i_cfg_data;
                CFG_HOLD_CAP:     r_cfg.hold_cap_ms     <= i_cfg_data;
                default:          r_cfg.hold_cap_ms     <= r_cfg.hold_cap_ms;
            endcase
        end
    end

    for (genvar b = 0; b < BUTTONS; b++) begin : g_btn
        logic pressed;
        if (b < BTN_INPUTS) begin : g_in
            assign pressed = btn_vec[b];
        end else begin : g_none
            assign pressed = 1'b0;
        end
        pkq_button_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_commit    (accept && grant.btn_go[b]),
            .i_now_ms    (i_now_ms),
            .i_pressed   (pressed),
            .i_cfg       (r_cfg),
            .i_short_act (btn_short_action(b)),
            .i_long_act  (btn_long_action(b)),
            .o_act       (btn_act[b])
        );
    end

    for (genvar k = 0; k < PAD_KEYS; k++) begin : g_key
        logic raw, rpt;
        if (k < PAD_INPUTS) begin : g_in
            assign raw = i_pad_keys[k];
            assign rpt = r_cfg.rpt_mask[k];
        end else begin : g_none
            assign raw = 1'b0;
            assign rpt = 1'b0;
        end
        pkq_key_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_commit  (accept && grant.key_go[k]),
            .i_now_ms  (i_now_ms),
            .i_raw     (raw),
            .i_cfg     (r_cfg),
            .i_rpt_en  (rpt),
            .i_is_left (k == LEFT_KEY),
            .i_key_act (key_action(k)),
            .o_act     (key_act[k])
        );
    end

    pkq_merge u_merge (
        .i_btn_act    (btn_act),
        .i_key_act    (key_act),
        .i_pad_active (pad_active),
        .o_grant      (grant)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= grant.action;
        end
    end

`ifndef SYNTH
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_out_valid && o_action == $past(grant.action)))
        else $error("poll transaction without following action");

    a_pad_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pad_active |-> (grant.key_go == '0))
        else $error("pad lane advanced while pad inactive");

    a_stop_after_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (grant.action != ACT_NONE) |-> !grant.key_go[PAD_KEYS-1]
            || key_act[PAD_KEYS-1] != ACT_NONE)
        else $error("lane after winning action still advancing");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

>>> sim/tb_button_and_pad_key_qualifier_unit.sv
// Self-checking testbench for button_and_pad_key_qualifier_unit.
// Drives polls and register writes, predicts each action code, and compares.
// Depends on pkq_pkg and the RTL of the unit.
module tb_button_and_pad_key_qualifier_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pkq_pkg::*;

    typedef struct {
        logic [31:0] t_now;
        bit          a;
        bit          b;
        bit          conn;
        bit [6:0]    keys;
        bit          typed;
        t_action     want;
    } t_poll_row;

    typedef struct {
        t_action act;
        int      seq;
    } t_due;

    localparam int      PHASES    = 10;
    localparam int      PHASE_LEN = 130;
    localparam t_action SHORT_ACTS [BUTTONS]  = '{ACT_RIGHT, ACT_CONFIRM};
    localparam t_action LONG_ACTS  [BUTTONS]  = '{ACT_BACK, ACT_LONG_LEFT};
    localparam t_action KEY_ACTS   [PAD_KEYS] = '{ACT_UP, ACT_DOWN, ACT_LEFT, ACT_RIGHT,
                                                 ACT_CONFIRM, ACT_BACK, ACT_HOME};

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [TIME_W-1:0]      i_now_ms;
    logic                   i_button_a_pressed;
    logic                   i_button_b_pressed;
    logic                   i_pad_connected;
    logic [PAD_INPUTS-1:0]  i_pad_keys;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [3:0]             o_action;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DAT_W-1:0]   i_cfg_data;

    button_and_pad_key_qualifier_unit uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_now_ms           (i_now_ms),
        .i_button_a_pressed (i_button_a_pressed),
        .i_button_b_pressed (i_button_b_pressed),
        .i_pad_connected    (i_pad_connected),
        .i_pad_keys         (i_pad_keys),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_action           (o_action),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // predictor state
    t_cfg        cfg;
    t_btn_phase  b_state [BUTTONS];
    logic [31:0] b_since [BUTTONS];
    bit          k_level [PAD_KEYS];
    bit          k_steady[PAD_KEYS];
    bit          k_freed [PAD_KEYS];
    bit          k_lleft [PAD_KEYS];
    logic [31:0] k_edge_t[PAD_KEYS];
    logic [31:0] k_down_t[PAD_KEYS];
    logic [31:0] k_next_t[PAD_KEYS];

    t_due        due_actions[$];
    int          err_cnt;
    int          poll_seq;
    bit          idle_on;
    logic [31:0] cur_t;
    bit          lv_a;
    bit          lv_b;
    bit          lv_conn;
    bit [6:0]    lv_keys;

    t_poll_row dir_rows [28] = '{
        '{32'd1000, 1'b0, 1'b0, 1'b1, 7'h01, 1'b1, ACT_NONE},
        '{32'd1040, 1'b0, 1'b0, 1'b1, 7'h01, 1'b1, ACT_NONE},
        '{32'd1050, 1'b0, 1'b0, 1'b1, 7'h00, 1'b0, ACT_NONE},
        '{32'd1100, 1'b0, 1'b0, 1'b1, 7'h00, 1'b0, ACT_NONE},
        '{32'd1110, 1'b1, 1'b0, 1'b1, 7'h00, 1'b0, ACT_NONE},
        '{32'd1120, 1'b0, 1'b0, 1'b1, 7'h00, 1'b1, ACT_NONE},
        '{32'd1200, 1'b1, 1'b0, 1'b1, 7'h00, 1'b0, ACT_NONE},
        '{32'd1230, 1'b0, 1'b0, 1'b1, 7'h00, 1'b1, ACT_RIGHT},
        '{32'd1300, 1'b0, 1'b1, 1'b1, 7'h00, 1'b0, ACT_NONE},
        '{32'd1800, 1'b0, 1'b1, 1'b1, 7'h00, 1'b1, ACT_NONE},
        '{32'd1801, 1'b0, 1'b1, 1'b1, 7'h00, 1'b1, ACT_LONG_LEFT},
        '{32'd1900, 1'b0, 1'b0, 1'b1, 7'h00, 1'b0, ACT_NONE},
        '{32'd2000, 1'b1, 1'b1, 1'b1, 7'h00, 1'b0, ACT_NONE},
        '{32'd2100, 1'b0, 1'b0, 1'b1, 7'h00, 1'b1, ACT_RIGHT},
        '{32'd2110, 1'b0, 1'b0, 1'b1, 7'h00, 1'b1, ACT_CONFIRM},
        '{32'd2200, 1'b1, 1'b0, 1'b1, 7'h00, 1'b0, ACT_NONE},
        '{32'd2701, 1'b1, 1'b0, 1'b1, 7'h00, 1'b1, ACT_BACK},
        '{32'd3000, 1'b0, 1'b0, 1'b1, 7'h7F, 1'b0, ACT_NONE},
        '{32'd3030, 1'b0, 1'b0, 1'b1, 7'h7F, 1'b1, ACT_UP},
        '{32'd3031, 1'b0, 1'b0, 1'b1, 7'h7F, 1'b1, ACT_DOWN},
        '{32'd3032, 1'b0, 1'b0, 1'b1, 7'h7F, 1'b1, ACT_LEFT},
        '{32'd3033, 1'b0, 1'b0, 1'b1, 7'h7F, 1'b1, ACT_RIGHT},
        '{32'd3034, 1'b0, 1'b0, 1'b1, 7'h7F, 1'b1, ACT_CONFIRM},
        '{32'd3035, 1'b0, 1'b0, 1'b1, 7'h7F, 1'b1, ACT_BACK},
        '{32'd3036, 1'b0, 1'b0, 1'b1, 7'h7F, 1'b1, ACT_HOME},
        '{32'd3100, 1'b0, 1'b0, 1'b0, 7'h00, 1'b1, ACT_NONE},
        '{32'hFFFF_FFF0, 1'b1, 1'b0, 1'b1, 7'h7F, 1'b0, ACT_NONE},
        '{32'h0000_0010, 1'b0, 1'b0, 1'b1, 7'h7F, 1'b1, ACT_RIGHT}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_button_and_pad_key_qualifier_unit: done, errors");
        $finish;
    end

    task automatic note_error(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // wrapping difference read as signed is at least lim
    function automatic bit since_ge(input logic [31:0] d, input logic [31:0] lim);
        return (d < 32'h8000_0000) && (d >= lim);
    endfunction

    function automatic t_action button_eval(input int i, input bit pressed,
                                            input logic [31:0] t_now);
        logic [31:0] dur;
        t_action     res;
        dur = t_now - b_since[i];
        res = ACT_NONE;
        case (b_state[i])
            PH_PRESSED: begin
                if (pressed) begin
                    if (dur > {16'h0, cfg.btn_long_ms}) begin
                        b_state[i] = PH_LONG;
                        res = LONG_ACTS[i];
                    end
                end else begin
                    b_state[i] = PH_IDLE;
                    if (dur >= {16'h0, cfg.btn_debounce_ms}) res = SHORT_ACTS[i];
                end
            end
            PH_LONG: begin
                if (!pressed) b_state[i] = PH_IDLE;
            end
            default: begin
                if (pressed) begin
                    b_state[i] = PH_PRESSED;
                    b_since[i] = t_now;
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_action key_eval(input int i, input bit raw, input logic [31:0] t_now);
        bit          nd;
        logic [31:0] held;
        logic [31:0] to_rpt;
        if (!raw) k_freed[i] = 1'b1;
        if (raw != k_level[i]) begin
            k_level[i]  = raw;
            k_edge_t[i] = t_now;
        end
        nd = since_ge(t_now - k_edge_t[i], {16'h0, cfg.pad_debounce_ms}) ? raw : k_steady[i];
        if (nd && !k_steady[i]) begin
            k_steady[i] = 1'b1;
            k_down_t[i] = t_now;
            k_next_t[i] = t_now + {16'h0, cfg.rpt_delay_ms};
            k_lleft[i]  = 1'b0;
            if (k_freed[i]) return KEY_ACTS[i];
        end else if (cfg.rpt_mask[i] && nd && k_steady[i] && k_freed[i]) begin
            held   = t_now - k_down_t[i];
            to_rpt = t_now - k_next_t[i];
            if (i == LEFT_KEY && !k_lleft[i] && since_ge(held, LONG_LEFT_MS)) begin
                k_lleft[i] = 1'b1;
                return ACT_LONG_LEFT;
            end
            if (!since_ge(held, {16'h0, cfg.hold_cap_ms}) && !to_rpt[31]) begin
                k_next_t[i] = t_now + {16'h0, cfg.rpt_period_ms};
                return KEY_ACTS[i];
            end
        end
        if (!nd && k_steady[i]) begin
            k_steady[i] = 1'b0;
            k_lleft[i]  = 1'b0;
        end
        return ACT_NONE;
    endfunction

    function automatic t_action qualify_poll(input logic [31:0] t_now, input bit a, input bit b,
                                             input bit conn, input bit [6:0] keys);
        t_action act;
        int      i;
        act = ACT_NONE;
        for (i = 0; i < BUTTONS && act == ACT_NONE; i++)
            act = button_eval(i, (i == 0) ? a : b, t_now);
        if (act == ACT_NONE && cfg.pad_enable && conn) begin
            for (i = 0; i < PAD_KEYS && act == ACT_NONE; i++)
                act = key_eval(i, keys[i], t_now);
        end
        return act;
    endfunction

    task automatic predictor_clear();
        cfg.btn_debounce_ms = 16'd30;
        cfg.btn_long_ms     = 16'd500;
        cfg.pad_enable      = 1'b1;
        cfg.pad_debounce_ms = 16'd30;
        cfg.rpt_mask        = '0;
        cfg.rpt_delay_ms    = 16'd450;
        cfg.rpt_period_ms   = 16'd110;
        cfg.hold_cap_ms     = 16'd1500;
        for (int i = 0; i < BUTTONS; i++) begin
            b_state[i] = PH_IDLE;
            b_since[i] = '0;
        end
        for (int i = 0; i < PAD_KEYS; i++) begin
            k_level[i]  = 1'b0;
            k_steady[i] = 1'b0;
            k_freed[i]  = 1'b0;
            k_lleft[i]  = 1'b0;
            k_edge_t[i] = '0;
            k_down_t[i] = '0;
            k_next_t[i] = '0;
        end
    endtask

    function automatic int gap_len();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_poll(input logic [31:0] t_now, input bit a, input bit b, input bit conn,
                             input bit [6:0] keys, input bit typed, input t_action want);
        int      gap;
        t_action act;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_now_ms           = t_now;
        i_button_a_pressed = a;
        i_button_b_pressed = b;
        i_pad_connected    = conn;
        i_pad_keys         = keys;
        i_in_valid         = 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        act = qualify_poll(t_now, a, b, conn, keys);
        due_actions.push_back('{typed ? want : act, poll_seq});
        poll_seq++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            CFG_BTN_DEBOUNCE: cfg.btn_debounce_ms = val;
            CFG_BTN_LONG:     cfg.btn_long_ms     = val;
            CFG_PAD_ENABLE:   cfg.pad_enable      = val[0];
            CFG_PAD_DEBOUNCE: cfg.pad_debounce_ms = val;
            CFG_RPT_MASK:     cfg.rpt_mask        = val[6:0];
            CFG_RPT_DELAY:    cfg.rpt_delay_ms    = val;
            CFG_RPT_PERIOD:   cfg.rpt_period_ms   = val;
            default:          cfg.hold_cap_ms     = val;
        endcase
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (due_actions.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic load_phase(input int p);
        logic [15:0] v [8];
        case (p)
            0: v = '{16'd30, 16'd500, 16'd1, 16'd30, 16'h7F, 16'd450, 16'd110, 16'd1500};
            1: v = '{16'd0, 16'd0, 16'd1, 16'd0, 16'h7F, 16'd0, 16'd0, 16'hFFFF};
            2: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7F, 16'hFFFF, 16'hFFFF,
                     16'hFFFF};
            3: v = '{16'd20, 16'd300, 16'd0, 16'd10, 16'h7F, 16'd100, 16'd50, 16'd800};
            default: begin
                v[0] = 16'($urandom_range(0, 200));
                v[1] = 16'($urandom_range(0, 1000));
                v[2] = 16'(($urandom_range(0, 9) != 0));
                v[3] = 16'($urandom_range(0, 100));
                v[4] = 16'($urandom_range(0, 127));
                v[5] = 16'($urandom_range(0, 800));
                v[6] = 16'($urandom_range(1, 200));
                v[7] = 16'($urandom_range(0, 3000));
            end
        endcase
        write_reg(CFG_BTN_DEBOUNCE, v[0]);
        write_reg(CFG_BTN_LONG,     v[1]);
        write_reg(CFG_PAD_ENABLE,   v[2]);
        write_reg(CFG_PAD_DEBOUNCE, v[3]);
        write_reg(CFG_RPT_MASK,     v[4]);
        write_reg(CFG_RPT_DELAY,    v[5]);
        write_reg(CFG_RPT_PERIOD,   v[6]);
        write_reg(CFG_HOLD_CAP,     v[7]);
        i_cfg_valid = 1'b0;
    endtask

    // mostly plausible press/hold/release traffic, some time jumps and random levels
    task automatic run_random(input int n, input int scale);
        int r;
        int kb;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 88) begin
                if (r < 8) cur_t += $urandom_range(0, scale * 8);
                else       cur_t += $urandom_range(0, scale);
                if ($urandom_range(0, 99) < 8) lv_a = !lv_a;
                if ($urandom_range(0, 99) < 8) lv_b = !lv_b;
                if ($urandom_range(0, 99) < 20) begin
                    kb = $urandom_range(0, 6);
                    lv_keys[kb] = !lv_keys[kb];
                end
                if (lv_conn) begin
                    if ($urandom_range(0, 99) < 2) lv_conn = 1'b0;
                end else if ($urandom_range(0, 99) < 30) begin
                    lv_conn = 1'b1;
                end
            end else begin
                case ($urandom_range(0, 2))
                    0: cur_t -= $urandom_range(1, scale);
                    1: cur_t = $urandom;
                    default: begin
                        lv_keys = 7'($urandom_range(0, 127));
                        lv_a    = 1'($urandom_range(0, 1));
                        lv_b    = 1'($urandom_range(0, 1));
                        lv_conn = 1'($urandom_range(0, 1));
                    end
                endcase
            end
            send_poll(cur_t, lv_a, lv_b, lv_conn, lv_keys, 1'b0, ACT_NONE);
        end
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!idle_on || $urandom_range(0, 99) < 60) begin
                i_out_ready = 1'b1;
            end else begin
                i_out_ready = 1'b0;
                if ($urandom_range(0, 99) < 90) repeat ($urandom_range(0, 2)) @(negedge i_clk);
                else                            repeat ($urandom_range(9, 39)) @(negedge i_clk);
            end
        end
    end

    // each action transaction is checked against the oldest prediction
    always @(posedge i_clk) begin
        t_due d;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_actions.size() == 0) begin
                note_error($sformatf("unexpected action %0d", o_action));
            end else begin
                d = due_actions.pop_front();
                if (o_action !== d.act)
                    note_error($sformatf("poll %0d: action %0d, expected %0d",
                                         d.seq, o_action, d.act));
            end
        end
    end

    initial begin
        int scale;
        err_cnt            = 0;
        poll_seq           = 0;
        idle_on            = 1'b1;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_now_ms           = '0;
        i_button_a_pressed = 1'b0;
        i_button_b_pressed = 1'b0;
        i_pad_connected    = 1'b0;
        i_pad_keys         = '0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = CFG_BTN_DEBOUNCE;
        i_cfg_data         = '0;
        lv_a               = 1'b0;
        lv_b               = 1'b0;
        lv_conn            = 1'b1;
        lv_keys            = '0;
        predictor_clear();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r])
            send_poll(dir_rows[r].t_now, dir_rows[r].a, dir_rows[r].b, dir_rows[r].conn,
                      dir_rows[r].keys, dir_rows[r].typed, dir_rows[r].want);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            load_phase(p);
            idle_on = (p % 3 != 2);
            cur_t   = (p == 1) ? 32'hFFFF_FF00 : $urandom;
            case (p)
                0:       scale = 40;
                1:       scale = 10;
                2:       scale = 20000;
                3:       scale = 100;
                default: scale = 60;
            endcase
            run_random(PHASE_LEN, scale);
        end

        settle();
        repeat (5) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_button_and_pad_key_qualifier_unit: done, clean");
        end else begin
            $display("tb_button_and_pad_key_qualifier_unit: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/pkq_pkg.sv
rtl/pkq_button_lane.sv
rtl/pkq_key_lane.sv
rtl/pkq_merge.sv
rtl/button_and_pad_key_qualifier_unit.sv
sim/tb_button_and_pad_key_qualifier_unit.sv
